FILE: rtl/core/fnvwp_pkg.sv
// Shared types, constants and the byte-round function for the word-pair digest.
// No dependencies; used by the controller, the datapath and the top level.
package fnvwp_pkg;

   localparam int unsigned HashWidth  = 64;
   localparam int unsigned WordWidth  = 64;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned PairWidth  = 2 * WordWidth;
   localparam int unsigned RoundCount = PairWidth / ByteWidth;
   localparam int unsigned CountWidth = $clog2(RoundCount);

   localparam logic [CountWidth-1:0] LastRound = CountWidth'(RoundCount - 1);

   localparam logic [HashWidth-1:0] DigestSeed = 64'd1469598103934665603;

   // prime = 2^40 + 435
   localparam int unsigned   PrimeShift = 40;
   localparam logic [8:0]    PrimeLow   = 9'd435;

   // one controller state per phase of an item
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FOLD,
      ST_POST
   } fnvwp_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture words, reseed if requested
      logic seed;     // with load: restart from the seed
      logic step;     // fold one byte
      logic publish;  // copy hash to the result register
   } fnvwp_cmd_type;

   // xor one byte, then multiply by the prime mod 2^64
   function automatic logic [HashWidth-1:0] fnv_round(
      input logic [HashWidth-1:0] h,
      input logic [ByteWidth-1:0] b
   );
      logic [HashWidth-1:0] x;
      logic [HashWidth-1:0] lo;
      x  = h ^ {{(HashWidth-ByteWidth){1'b0}}, b};
      lo = x * {{(HashWidth-9){1'b0}}, PrimeLow};
      return (x << PrimeShift) + lo;
   endfunction

endpackage

FILE: rtl/core/fnvwp_ctrl.sv
// Sequencer for the word-pair digest: accept, sixteen byte rounds, publish.
// Depends on fnvwp_pkg; drives the datapath through fnvwp_cmd_type.
module fnvwp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output fnvwp_pkg::fnvwp_cmd_type cmd
);
   import fnvwp_pkg::*;

   fnvwp_state_type         state_ff, state_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            count_in   = '0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cmd.seed = ~req_tuser;
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == LastRound) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            // wait until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.publish}))
      else $error("more than one datapath command at once");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_tready))
      else $error("publish over an untaken result");

   a_accept_folds: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_FOLD && count_ff == '0))
      else $error("accepted request did not start folding");

   a_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD && count_ff == LastRound) |=> state_ff == ST_POST)
      else $error("fold did not end after the last round");
`endif

endmodule

FILE: rtl/core/fnvwp_dpath.sv
// Datapath for the word-pair digest: running hash, byte shifter, result register.
// Depends on fnvwp_pkg for the round function and the command struct.
module fnvwp_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fnvwp_pkg::fnvwp_cmd_type             cmd,
   input  logic [fnvwp_pkg::PairWidth-1:0]      req_tdata,
   output logic [fnvwp_pkg::HashWidth-1:0]      rsp_tdata
);
   import fnvwp_pkg::*;

   logic [HashWidth-1:0] hash_ff, hash_in;
   logic [PairWidth-1:0] word_ff, word_in;
   logic [HashWidth-1:0] digest_ff;

   always_comb begin
      hash_in = hash_ff;
      word_in = word_ff;
      if (cmd.load) begin
         word_in = req_tdata;
         if (cmd.seed) begin
            hash_in = DigestSeed;
         end
      end else if (cmd.step) begin
         hash_in = fnv_round(hash_ff, word_ff[ByteWidth-1:0]);
         word_in = word_ff >> ByteWidth;
      end
   end

   // running hash is architectural state: reset to the seed
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= DigestSeed;
      end else begin
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (cmd.publish) begin
         digest_ff <= hash_ff;
      end
   end

   assign rsp_tdata = digest_ff;

endmodule

FILE: rtl/core/fnv1a_word_pair_digest.sv
// Top level of the word-pair digest: controller plus datapath.
// Depends on fnvwp_pkg, fnvwp_ctrl and fnvwp_dpath.
//
// Running 64-bit FNV-1a style digest over pairs of 64-bit words. Each request
// folds first_word then second_word, least significant byte first: per byte
// the hash is XORed with the byte and multiplied by 1099511628211 mod 2^64.
// A begin request (tuser = 0) first reseeds the hash with 1469598103934665603
// (not the standard offset basis); a pair request (tuser = 1) continues from
// the running hash, which also holds the seed after reset. Every request
// returns one response carrying the digest after its two words.
// Sequence: after a request is accepted the block runs sixteen byte rounds, at
// one round per cycle in the shared round unit, then a publish step that copies
// the hash into the result register; a request is captured in the idle state,
// so requests are taken one at a time.
// The result sits in its own register, so the next request is accepted while
// a result waits to be taken; a request only stalls at publish time if the
// previous result is still held.
module fnv1a_word_pair_digest (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fnvwp_pkg::PairWidth-1:0]     req_tdata,  // [63:0] first_word, [127:64] second_word
   input  logic                                req_tuser,  // [0] func: 0 begin, 1 pair
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fnvwp_pkg::HashWidth-1:0]     rsp_tdata   // [63:0] digest
);
   import fnvwp_pkg::*;

   fnvwp_cmd_type cmd;

   fnvwp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fnvwp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

FILE: bench/tb_fnv1a_word_pair_digest.sv
// Self-checking bench for fnv1a_word_pair_digest: directed table, then random
// begin/pair sequences, with random idling on both channels and a digest predictor.
// Depends on fnvwp_pkg and the RTL top fnv1a_word_pair_digest.
module tb_fnv1a_word_pair_digest;

   typedef logic [fnvwp_pkg::WordWidth-1:0] word_type;

   // tuser codes
   typedef enum logic {
      FUNC_BEGIN = 1'b0,
      FUNC_PAIR  = 1'b1
   } func_type;

   typedef struct packed {
      func_type func;
      word_type first_word;
      word_type second_word;
   } request_type;

   localparam word_type    FNV_PRIME      = 64'd1099511628211;
   localparam int unsigned TOTAL_REQUESTS = 1150;
   localparam int unsigned HOLD_CYCLES    = 250;   // long receiver hold-off
   localparam int unsigned HOLD_SPACING   = 350;   // requests between hold-offs
   localparam int unsigned HOLD_LIMIT     = 2;
   localparam int unsigned TAIL_CYCLES    = 40;    // > result latency
   localparam int unsigned DRAIN_LIMIT    = 20000;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [fnvwp_pkg::PairWidth-1:0]     req_tdata;   // [63:0] first_word, [127:64] second_word
   logic                                req_tuser;   // [0] func: 0 begin, 1 pair
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [fnvwp_pkg::HashWidth-1:0]     rsp_tdata;   // [63:0] digest

   // digest predictor state and the store of digests still owed by the block
   word_type    chain_hash;
   word_type    expected_digest;
   word_type    pending_digests [$];

   int unsigned requests_taken;
   int unsigned begins_taken;
   int unsigned pairs_taken;
   int unsigned digests_checked;
   int unsigned error_count;
   int unsigned holds_done;
   int unsigned drains_done;
   logic        steady_flow;   // set: no gaps on either side

   fnv1a_word_pair_digest u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop, several times the slowest legal run.
   initial begin
      #4800000;
      $display("%0t: timeout", $time);
      $display("** fnv1a_word_pair_digest: FAILED **");
      $finish;
   end

   // Fold one 64-bit word into the hash, low byte first: xor, then multiply.
   function automatic word_type fold_word(input word_type h, input word_type w);
      word_type acc;
      acc = h;
      for (int k = 0; k < 8; k++) begin
         acc = (acc ^ {56'd0, w[8*k +: 8]}) * FNV_PRIME;
      end
      return acc;
   endfunction

   // Sender gap: mostly none or short, now and then long enough to span a
   // whole item.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 17);
      return $urandom_range(18, 40);
   endfunction

   // Pair payload: mostly full random bits, plus flat patterns, single bits
   // and plausible doubles.
   function automatic word_type pick_word();
      int unsigned r;
      word_type    w;
      r = $urandom_range(0, 99);
      w = {$urandom, $urandom};
      if (r < 8) begin
         w = '0;
      end else if (r < 16) begin
         w = '1;
      end else if (r < 26) begin
         w = word_type'(1) << $urandom_range(0, 63);
      end else if (r < 40) begin
         w[62:52] = 11'(1003 + $urandom_range(0, 40));
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: checks responses against the oldest pending digest, then
   // predicts the digest for any request taken on the same edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         chain_hash = fnvwp_pkg::DigestSeed;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_digests.size() == 0) begin
               $display("%0t: response with nothing pending, got %h", $time, rsp_tdata);
               error_count++;
            end else begin
               expected_digest = pending_digests.pop_front();
               digests_checked++;
               if (rsp_tdata !== expected_digest) begin
                  $display("%0t: digest mismatch, expected %h, got %h",
                           $time, expected_digest, rsp_tdata);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            // a begin reseeds; a pair carries on from the running hash
            if (func_type'(req_tuser) == FUNC_BEGIN) begin
               chain_hash = fnvwp_pkg::DigestSeed;
               begins_taken++;
            end else begin
               pairs_taken++;
            end
            chain_hash = fold_word(chain_hash, req_tdata[63:0]);
            chain_hash = fold_word(chain_hash, req_tdata[127:64]);
            pending_digests.push_back(chain_hash);
            requests_taken++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random ready with short and long stalls; twice it holds off
   // for a long stretch so the result register fills and req_tready drops.
   // ------------------------------------------------------------------
   initial begin
      int unsigned stall_left;
      int unsigned r;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && holds_done < HOLD_LIMIT &&
             requests_taken >= HOLD_SPACING * (holds_done + 1)) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            holds_done++;
         end else if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (steady_flow) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else if (r < 93) begin
               rsp_tready <= 1'b0;
               stall_left = $urandom_range(0, 2);
            end else begin
               rsp_tready <= 1'b0;
               stall_left = $urandom_range(8, 40);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender. Called at a falling edge; returns at the falling edge after
   // the request is taken, leaving req_tvalid high so back-to-back requests
   // need no toggle. Anything that pauses must lower req_tvalid itself.
   // ------------------------------------------------------------------
   int unsigned requests_sent;

   task automatic send_request(input func_type func, input word_type first_word,
                               input word_type second_word);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {second_word, first_word};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      requests_sent++;
   endtask

   // Sender pause: nothing offered until every pending digest is back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_digests.size() != 0);
      drains_done++;
   endtask

   // Begin announcing timestamp and rate counts, then pair_total pairs.
   task automatic send_series(input word_type ts_count, input word_type rate_count,
                              input int unsigned pair_total);
      send_request(FUNC_BEGIN, ts_count, rate_count);
      repeat (pair_total) send_request(FUNC_PAIR, pick_word(), pick_word());
   endtask

   // Directed table. No digest here can be read off by eye, so every row is
   // checked by the predictor.
   request_type directed_rows [0:19] = '{
      '{FUNC_PAIR,  64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000}, // pair off reset seed
      '{FUNC_PAIR,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, // still no begin
      '{FUNC_BEGIN, 64'd0,                   64'd0},                   // empty series
      '{FUNC_BEGIN, 64'd2,                   64'd2},                   // repeated begin
      '{FUNC_PAIR,  64'h0000_0190_0000_0000, 64'h3FF0_0000_0000_0000}, // rate 1.0
      '{FUNC_PAIR,  64'h0123_4567_89AB_CDEF, 64'hBFF0_0000_0000_0000}, // rate -1.0
      '{FUNC_PAIR,  64'hFFFF_FFFF_FFFF_FFFF, 64'h7FF8_0000_0000_0000}, // one pair too many, NaN
      '{FUNC_BEGIN, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, // max counts
      '{FUNC_PAIR,  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000}, // -0.0
      '{FUNC_PAIR,  64'h0000_0000_0000_00FF, 64'hFF00_0000_0000_0000}, // byte order
      '{FUNC_PAIR,  64'hFF00_0000_0000_0000, 64'h0000_0000_0000_00FF},
      '{FUNC_BEGIN, 64'd1,                   64'd0},                   // counts disagree
      '{FUNC_BEGIN, 64'd0,                   64'd1},
      '{FUNC_PAIR,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
      '{FUNC_PAIR,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
      '{FUNC_BEGIN, 64'd3,                   64'd5},
      '{FUNC_PAIR,  64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000}, // +inf, -inf
      '{FUNC_PAIR,  64'h0000_0000_0000_0001, 64'h0000_0000_0000_0001}, // denormal
      '{FUNC_PAIR,  64'h7FEF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000}, // largest, smallest normal
      '{FUNC_BEGIN, 64'h8000_0000_0000_0000, 64'd1}
   };

   initial begin
      int unsigned kind;
      int unsigned n;
      int unsigned drain_cycles;
      word_type    other_count;

      reset           <= 1'b1;
      req_tvalid      <= 1'b0;
      req_tuser       <= FUNC_BEGIN;
      req_tdata       <= '0;
      steady_flow     = 1'b0;
      requests_sent   = 0;
      requests_taken  = 0;
      begins_taken    = 0;
      pairs_taken     = 0;
      digests_checked = 0;
      error_count     = 0;
      holds_done      = 0;
      drains_done     = 0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].func, directed_rows[i].first_word,
                      directed_rows[i].second_word);
      end
      wait_for_drain();

      // Random part: mostly well-formed series (begin, then min(count, count)
      // pairs), some series whose pair count is off, and some noise.
      while (requests_sent < TOTAL_REQUESTS) begin
         steady_flow = ($urandom_range(0, 99) < 15);
         if ($urandom_range(0, 99) < 4) wait_for_drain();
         kind = $urandom_range(0, 99);
         n    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
         other_count = word_type'(n + $urandom_range(0, 3));
         if (kind < 75) begin
            if ($urandom_range(0, 1) != 0) begin
               send_series(word_type'(n), other_count, n);
            end else begin
               send_series(other_count, word_type'(n), n);
            end
         end else if (kind < 90) begin
            // announced counts and pairs sent disagree
            send_series(word_type'(n), other_count, n + $urandom_range(1, 3));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_request(func_type'($urandom_range(0, 1)), {$urandom, $urandom},
                            {$urandom, $urandom});
            end
         end
      end
      steady_flow = 1'b0;

      // wind down: stop offering, collect everything, then watch for strays
      req_tvalid <= 1'b0;
      drain_cycles = 0;
      while (pending_digests.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_digests.size() != 0) begin
         $display("%0t: %0d digests never arrived", $time, pending_digests.size());
         error_count++;
      end

      $display("Covered %0d requests (%0d begin, %0d pair), %0d digests checked,",
               requests_taken, begins_taken, pairs_taken, digests_checked);
      $display("%0d long receiver hold-offs, %0d sender drains, %0d errors.",
               holds_done, drains_done, error_count);
      if (error_count == 0) begin
         $display("** fnv1a_word_pair_digest: PASSED **");
      end else begin
         $display("** fnv1a_word_pair_digest: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/fnvwp_pkg.sv
rtl/core/fnvwp_ctrl.sv
rtl/core/fnvwp_dpath.sv
rtl/core/fnv1a_word_pair_digest.sv
bench/tb_fnv1a_word_pair_digest.sv
